>>> rtl/core/hrpc_pkg.sv
// hrpc_pkg: types, constants, prime table and helper functions for the
// rehash policy check block. No dependencies; imported by every hrpc module.
`timescale 1ns / 1ps

package hrpc_pkg;

   localparam int unsigned CNT_W      = 32;
   localparam int unsigned FIX_W      = 24;
   localparam int unsigned SUM_W      = CNT_W + 1;
   localparam int unsigned FRAC_W     = 16;
   localparam int unsigned PROD_W     = CNT_W + FIX_W;
   localparam int unsigned DIVIDEND_W = SUM_W + FRAC_W;
   localparam int unsigned CSR_IDX_W  = 8;

   localparam int unsigned ROM_SIZE    = 256;
   localparam int unsigned PRIME_COUNT = 256;
   localparam int unsigned ROM_IDX_W   = $clog2(ROM_SIZE);
   localparam int unsigned SRCH_W      = ROM_IDX_W + 1;

   localparam logic [CNT_W-1:0] PRIME_CEILING = 32'd4294967291;
   localparam logic [CNT_W-1:0] CNT_MAX       = {CNT_W{1'b1}};
   localparam logic [FIX_W-1:0] LOAD_RESET    = 24'd65536;
   localparam logic [FIX_W-1:0] GROWTH_RESET  = 24'd131072;

   localparam logic [CSR_IDX_W-1:0] CSR_MAX_LOAD = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GROWTH   = 8'd1;

   typedef struct packed {
      logic [CNT_W-1:0] bucket_count;
      logic [CNT_W-1:0] element_count;
      logic [CNT_W-1:0] element_add;
   } hrpc_req_type;

   typedef struct packed {
      logic             rehash_needed;
      logic [CNT_W-1:0] new_bucket_count;
   } hrpc_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_MUL_BL,
      ST_DIV,
      ST_SEARCH,
      ST_MUL_PL,
      ST_EMIT
   } hrpc_state_type;

   localparam logic [CNT_W-1:0] PRIME_ROM [0:ROM_SIZE-1] = '{
      32'd2, 32'd3, 32'd5, 32'd7, 32'd11, 32'd13, 32'd17, 32'd19, 32'd23, 32'd29, 32'd31,
      32'd37, 32'd41, 32'd43, 32'd47, 32'd53, 32'd59, 32'd61, 32'd67, 32'd71, 32'd73,
      32'd79, 32'd83, 32'd89, 32'd97, 32'd103, 32'd109, 32'd113, 32'd127, 32'd137,
      32'd139, 32'd149, 32'd157, 32'd167, 32'd179, 32'd193, 32'd199, 32'd211, 32'd227,
      32'd241, 32'd257, 32'd277, 32'd293, 32'd313, 32'd337, 32'd359, 32'd383, 32'd409,
      32'd439, 32'd467, 32'd503, 32'd541, 32'd577, 32'd619, 32'd661, 32'd709, 32'd761,
      32'd823, 32'd887, 32'd953, 32'd1031, 32'd1109, 32'd1193, 32'd1289, 32'd1381,
      32'd1493, 32'd1613, 32'd1741, 32'd1879, 32'd2029, 32'd2179, 32'd2357, 32'd2549,
      32'd2753, 32'd2971, 32'd3209, 32'd3469, 32'd3739, 32'd4027, 32'd4349, 32'd4703,
      32'd5087, 32'd5503, 32'd5953, 32'd6427, 32'd6949, 32'd7517, 32'd8123, 32'd8783,
      32'd9497, 32'd10273, 32'd11113, 32'd12011, 32'd12983, 32'd14033, 32'd15173,
      32'd16411, 32'd17749, 32'd19183, 32'd20753, 32'd22447, 32'd24281, 32'd26267,
      32'd28411, 32'd30727, 32'd33223, 32'd35933, 32'd38873, 32'd42043, 32'd45481,
      32'd49201, 32'd53201, 32'd57557, 32'd62233, 32'd67307, 32'd72817, 32'd78779,
      32'd85229, 32'd92203, 32'd99733, 32'd107897, 32'd116731, 32'd126271, 32'd136607,
      32'd147793, 32'd159871, 32'd172933, 32'd187091, 32'd202409, 32'd218971,
      32'd236897, 32'd256279, 32'd277261, 32'd299951, 32'd324503, 32'd351061,
      32'd379787, 32'd410857, 32'd444487, 32'd480881, 32'd520241, 32'd562841,
      32'd608903, 32'd658753, 32'd712697, 32'd771049, 32'd834181, 32'd902483,
      32'd976369, 32'd1056323, 32'd1142821, 32'd1236397, 32'd1337629, 32'd1447153,
      32'd1565659, 32'd1693859, 32'd1832561, 32'd1982627, 32'd2144977, 32'd2320627,
      32'd2510653, 32'd2716249, 32'd2938679, 32'd3179303, 32'd3439651, 32'd3721303,
      32'd4026031, 32'd4355707, 32'd4712381, 32'd5098259, 32'd5515729, 32'd5967347,
      32'd6456007, 32'd6984629, 32'd7556579, 32'd8175383, 32'd8844859, 32'd9569143,
      32'd10352717, 32'd11200489, 32'd12117689, 32'd13109983, 32'd14183539,
      32'd15345007, 32'd16601593, 32'd17961079, 32'd19431899, 32'd21023161,
      32'd22744717, 32'd24607243, 32'd26622317, 32'd28802401, 32'd31160981,
      32'd33712729, 32'd36473443, 32'd39460231, 32'd42691603, 32'd46187573,
      32'd49969847, 32'd54061849, 32'd58488943, 32'd63278561, 32'd68460391,
      32'd74066549, 32'd80131819, 32'd86693767, 32'd93793069, 32'd101473717,
      32'd109783337, 32'd118773397, 32'd128499677, 32'd139022417, 32'd150406843,
      32'd162723577, 32'd176048909, 32'd190465427, 32'd206062531, 32'd222936881,
      32'd241193053, 32'd260944219, 32'd282312799, 32'd305431229, 32'd330442829,
      32'd357502601, 32'd386778277, 32'd418451333, 32'd452718089, 32'd489790921,
      32'd529899637, 32'd573292817, 32'd620239453, 32'd671030513, 32'd725980837,
      32'd785430967, 32'd849749479, 32'd919334987, 32'd994618837, 32'd1076067617,
      32'd1164186217, 32'd1259520799, 32'd1362662261, 32'd1474249943, 32'd1594975441,
      32'd1725587117, 32'd1866894511, 32'd2019773507, 32'd2185171673, 32'd2364114217,
      32'd2557710269, 32'd2767159799, 32'd2993761039, 32'd3238918481, 32'd3504151727,
      32'd3791104843, 32'd4101556399, 32'd4294967291
   };

   // ceil(p / 2^16), saturated to 32 bits
   function automatic logic [CNT_W-1:0] ceil_sat(input logic [PROD_W-1:0] p);
      logic [PROD_W-FRAC_W-1:0] t;
      t = p[PROD_W-1:FRAC_W] + {{(PROD_W-FRAC_W-1){1'b0}}, |p[FRAC_W-1:0]};
      return (|t[PROD_W-FRAC_W-1:CNT_W]) ? CNT_MAX : t[CNT_W-1:0];
   endfunction

   // floor(p / 2^16), saturated to 32 bits
   function automatic logic [CNT_W-1:0] floor_sat(input logic [PROD_W-1:0] p);
      return (|p[PROD_W-1:CNT_W+FRAC_W]) ? CNT_MAX : p[CNT_W+FRAC_W-1:FRAC_W];
   endfunction

endpackage

>>> rtl/core/hrpc_serial_mul.sv
// hrpc_serial_mul: bit-serial shift-add multiplier, 32-bit by 24-bit.
// Depends on hrpc_pkg.
`timescale 1ns / 1ps

module hrpc_serial_mul (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [hrpc_pkg::CNT_W-1:0]  mcand,
   input  logic [hrpc_pkg::FIX_W-1:0]  mplier,
   output logic [hrpc_pkg::PROD_W-1:0] prod,
   output logic                      done
);
   import hrpc_pkg::*;

   localparam int unsigned STEP_W = $clog2(FIX_W);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(FIX_W - 1);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [CNT_W-1:0]    mcand_ff, mcand_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [CNT_W:0]      acc;

   // upper half accumulates, multiplier bits shift out at the bottom
   assign acc = {1'b0, prod_ff[PROD_W-1:FIX_W]} +
                (prod_ff[0] ? {1'b0, mcand_ff} : {(CNT_W+1){1'b0}});

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      step_in  = step_ff;
      mcand_in = mcand_ff;
      prod_in  = prod_ff;
      if (start) begin
         busy_in  = 1'b1;
         step_in  = '0;
         mcand_in = mcand;
         prod_in  = {{CNT_W{1'b0}}, mplier};
      end else if (busy_ff) begin
         prod_in = {acc, prod_ff[FIX_W-1:1]};
         step_in = step_ff + 1'b1;
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      mcand_ff <= mcand_in;
      prod_ff  <= prod_in;
   end

   assign prod = prod_ff;
   assign done = done_ff;

endmodule

>>> rtl/core/hrpc_serial_div.sv
// hrpc_serial_div: restoring divider, one quotient bit per cycle, 49-bit
// dividend by 24-bit divisor, quotient saturated to 32 bits. Depends on hrpc_pkg.
`timescale 1ns / 1ps

module hrpc_serial_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [hrpc_pkg::DIVIDEND_W-1:0] dividend,
   input  logic [hrpc_pkg::FIX_W-1:0]      divisor,
   output logic [hrpc_pkg::CNT_W-1:0]      quotient,
   output logic                          done
);
   import hrpc_pkg::*;

   localparam int unsigned STEP_W = $clog2(DIVIDEND_W);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIVIDEND_W - 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [FIX_W-1:0]      dvsr_ff, dvsr_in;
   logic [FIX_W-1:0]      rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] qr_ff, qr_in;
   logic [FIX_W:0]        trial;
   logic [FIX_W:0]        diff;
   logic                  fits;

   assign trial = {rem_ff, qr_ff[DIVIDEND_W-1]};
   assign diff  = trial - {1'b0, dvsr_ff};
   assign fits  = (trial >= {1'b0, dvsr_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      dvsr_in = dvsr_ff;
      rem_in  = rem_ff;
      qr_in   = qr_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         dvsr_in = divisor;
         rem_in  = '0;
         qr_in   = dividend;
      end else if (busy_ff) begin
         // a zero divisor always fits, so the quotient comes out all ones
         rem_in  = fits ? diff[FIX_W-1:0] : trial[FIX_W-1:0];
         qr_in   = {qr_ff[DIVIDEND_W-2:0], fits};
         step_in = step_ff + 1'b1;
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      dvsr_ff <= dvsr_in;
      rem_ff  <= rem_in;
      qr_ff   <= qr_in;
   end

   assign quotient = (|qr_ff[DIVIDEND_W-1:CNT_W]) ? CNT_MAX : qr_ff[CNT_W-1:0];
   assign done     = done_ff;

endmodule

>>> rtl/core/hrpc_prime_search.sv
// hrpc_prime_search: lower-bound binary search over the prime table, one
// probe per cycle, saturating at the ceiling prime. Depends on hrpc_pkg.
`timescale 1ns / 1ps

module hrpc_prime_search (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [hrpc_pkg::CNT_W-1:0] target,
   output logic [hrpc_pkg::CNT_W-1:0] prime,
   output logic                     done
);
   import hrpc_pkg::*;

   localparam logic [SRCH_W-1:0] LIMIT = SRCH_W'(PRIME_COUNT);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [CNT_W-1:0]   target_ff, target_in;
   logic [SRCH_W-1:0]  lo_ff, lo_in;
   logic [SRCH_W-1:0]  hi_ff, hi_in;
   logic [CNT_W-1:0]   prime_ff, prime_in;
   logic [SRCH_W:0]    mid_sum;
   logic [SRCH_W-1:0]  mid;

   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid     = mid_sum[SRCH_W:1];

   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      target_in = target_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      prime_in  = prime_ff;
      if (start) begin
         busy_in   = 1'b1;
         target_in = target;
         lo_in     = '0;
         hi_in     = LIMIT;
      end else if (busy_ff) begin
         if (lo_ff == hi_ff) begin
            busy_in  = 1'b0;
            done_in  = 1'b1;
            prime_in = (lo_ff == LIMIT) ? PRIME_CEILING : PRIME_ROM[lo_ff[ROM_IDX_W-1:0]];
         end else if (PRIME_ROM[mid[ROM_IDX_W-1:0]] < target_ff) begin
            lo_in = mid + 1'b1;
         end else begin
            hi_in = mid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      target_ff <= target_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      prime_ff  <= prime_in;
   end

   assign prime = prime_ff;
   assign done  = done_ff;

endmodule

>>> rtl/core/hash_rehash_policy_check_core.sv
// hash_rehash_policy_check_core: top level of the rehash policy check.
// Depends on hrpc_pkg, hrpc_serial_mul, hrpc_serial_div, hrpc_prime_search.
//
// Usage: one request beat carries bucket, element and add counts; one response
// beat comes back for every request, with the rehash flag and the prime bucket
// count to grow to (0 when no rehash). The csr channel sets the maximum load
// factor (index 0) and growth factor (index 1), both Q8.16; csr_ready is
// always high. Write them only while no request is in flight.
// A sum of counts within the stored threshold is answered at once; otherwise the
// buckets are multiplied by the load factor, and the response follows that
// product when the table keeps its size. On a rehash the 49-step restoring
// divider runs beside a second pass through the 24-step serial multiplier;
// up to 9 probes of the prime table and a third pass follow. One request is
// worked on at a time; the next is taken once the result has moved into the
// output register. Reset (synchronous) clears the threshold to 0 and loads
// load factor 1.0 and growth factor 2.0. While rsp_stall holds, the response
// beat stays in place; a finished result for the next request waits in the core.
`timescale 1ns / 1ps

module hash_rehash_policy_check_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  hrpc_pkg::hrpc_req_type            req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output hrpc_pkg::hrpc_rsp_type            rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [hrpc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [hrpc_pkg::FIX_W-1:0]        csr_wdata
);
   import hrpc_pkg::*;

   hrpc_state_type    state_ff, state_in;

   logic [FIX_W-1:0]  load_ff, load_in;
   logic [FIX_W-1:0]  growth_ff, growth_in;
   logic [CNT_W-1:0]  thr_ff, thr_in;
   logic [CNT_W-1:0]  bkt_ff, bkt_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic              rehash_ff, rehash_in;
   logic [CNT_W-1:0]  prime_ff, prime_in;
   logic              rsp_valid_ff, rsp_valid_in;
   hrpc_rsp_type      rsp_data_ff, rsp_data_in;

   logic              accept;
   logic              rsp_free;
   logic              over;
   logic              grow;
   logic [CNT_W-1:0]  grown;
   logic [CNT_W-1:0]  need;

   logic              mul_start, mul_done;
   logic [CNT_W-1:0]  mul_a;
   logic [FIX_W-1:0]  mul_m;
   logic [PROD_W-1:0] mul_prod;
   logic              div_start, div_done;
   logic [CNT_W-1:0]  div_q;
   logic              srch_start, srch_done;
   logic [CNT_W-1:0]  srch_prime;
   logic              thr_load;
   logic              res_clear;
   logic              res_set;
   logic              rsp_load;

   hrpc_serial_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .mcand  (mul_a),
      .mplier (mul_m),
      .prod   (mul_prod),
      .done   (mul_done)
   );

   hrpc_serial_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({sum_ff, {FRAC_W{1'b0}}}),
      .divisor  (load_ff),
      .quotient (div_q),
      .done     (div_done)
   );

   hrpc_prime_search u_srch (
      .clock  (clock),
      .reset  (reset),
      .start  (srch_start),
      .target (need),
      .prime  (srch_prime),
      .done   (srch_done)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid & ~req_stall;
   assign rsp_free  = ~rsp_valid_ff | ~rsp_stall;
   assign csr_ready = 1'b1;

   assign over  = (sum_ff > {1'b0, thr_ff});
   // sum * 2^16 against buckets * load
   assign grow  = ({{(PROD_W-DIVIDEND_W){1'b0}}, sum_ff, {FRAC_W{1'b0}}} > mul_prod);
   // product holds buckets * growth once the divide finishes
   assign grown = floor_sat(mul_prod);
   assign need  = (grown > div_q) ? grown : div_q;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (accept) state_in = ST_START;
         ST_START:  state_in = over ? ST_MUL_BL : ST_EMIT;
         ST_MUL_BL: if (mul_done) state_in = grow ? ST_DIV : ST_EMIT;
         ST_DIV:    if (div_done) state_in = ST_SEARCH;
         ST_SEARCH: if (srch_done) state_in = ST_MUL_PL;
         ST_MUL_PL: if (mul_done) state_in = ST_EMIT;
         ST_EMIT:   if (rsp_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      mul_start  = 1'b0;
      mul_a      = bkt_ff;
      mul_m      = load_ff;
      div_start  = 1'b0;
      srch_start = 1'b0;
      thr_load   = 1'b0;
      res_clear  = 1'b0;
      res_set    = 1'b0;
      rsp_load   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
         end
         ST_START: begin
            res_clear = 1'b1;
            mul_start = over;
         end
         ST_MUL_BL: begin
            mul_m = growth_ff;
            if (mul_done) begin
               mul_start = grow;
               div_start = grow;
               thr_load  = ~grow;
            end
         end
         ST_DIV: begin
            srch_start = div_done;
         end
         ST_SEARCH: begin
            mul_a     = srch_prime;
            mul_start = srch_done;
         end
         ST_MUL_PL: begin
            if (mul_done) begin
               thr_load = 1'b1;
               res_set  = 1'b1;
            end
         end
         ST_EMIT: begin
            rsp_load = rsp_free;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      load_in   = load_ff;
      growth_in = growth_ff;
      if (csr_valid & csr_ready) begin
         unique case (csr_index)
            CSR_MAX_LOAD: load_in   = csr_wdata;
            CSR_GROWTH:   growth_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      thr_in       = thr_load ? ceil_sat(mul_prod) : thr_ff;
      // a single bucket counts as none
      bkt_in       = bkt_ff;
      sum_in       = sum_ff;
      if (accept) begin
         bkt_in = (req_data.bucket_count == CNT_W'(1)) ? '0 : req_data.bucket_count;
         sum_in = {1'b0, req_data.element_count} + {1'b0, req_data.element_add};
      end
      rehash_in    = res_clear ? 1'b0 : (res_set ? 1'b1 : rehash_ff);
      prime_in     = res_clear ? '0 : (srch_done ? srch_prime : prime_ff);
      rsp_data_in  = rsp_data_ff;
      if (rsp_load) begin
         rsp_data_in.rehash_needed    = rehash_ff;
         rsp_data_in.new_bucket_count = rehash_ff ? prime_ff : '0;
      end
      rsp_valid_in = rsp_load | (rsp_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         load_ff      <= LOAD_RESET;
         growth_ff    <= GROWTH_RESET;
         thr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         load_ff      <= load_in;
         growth_ff    <= growth_in;
         thr_ff       <= thr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      bkt_ff      <= bkt_in;
      sum_ff      <= sum_in;
      rehash_ff   <= rehash_in;
      prime_ff    <= prime_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
